// File: hw/rtl/tap_pkg.sv
// Types and constants for the two-attractor particle step pipeline.
package tap_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_B1_X = 3'd0,
        REG_B1_Y = 3'd1,
        REG_B1_R = 3'd2,
        REG_B1_S = 3'd3,
        REG_B2_X = 3'd4,
        REG_B2_Y = 3'd5,
        REG_B2_R = 3'd6,
        REG_B2_S = 3'd7
    } cfg_idx_t;

    // Capture codes
    typedef enum logic [1:0] {
        CAP_FREE   = 2'd0,
        CAP_FIRST  = 2'd1,
        CAP_SECOND = 2'd2
    } cap_t;

    localparam logic signed [31:0] B1_X_RST = 32'sd9830400;
    localparam logic signed [31:0] B1_Y_RST = 32'sd13107200;
    localparam logic [30:0]        B1_R_RST = 31'd3276800;
    localparam logic [31:0]        B1_S_RST = 32'd78643200;
    localparam logic signed [31:0] B2_X_RST = 32'sd58982400;
    localparam logic signed [31:0] B2_Y_RST = 32'sd19660800;
    localparam logic [30:0]        B2_R_RST = 31'd13107200;
    localparam logic [31:0]        B2_S_RST = 32'd196608000;

    localparam int SQRT_STAGES = 16;   // 32 root bits, two per stage
    localparam int DIV1_STAGES = 32;   // 64 quotient bits, two per stage
    localparam int DIV2_STAGES = 16;   // 31 quotient bits, two per stage, one in the last
    localparam int DIV2_STEPS  = 31;
    localparam int FRONT_STAGES = 4;
    localparam int TAIL_STAGES  = 8;
    localparam int LATENCY = FRONT_STAGES + DIV1_STAGES + TAIL_STAGES;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [15:0]        dt;
    } particle_t;

    // Per-body geometry carried alongside the iterative units
    typedef struct packed {
        logic [32:0] mag_x;
        logic [32:0] mag_y;
        logic        neg_x;
        logic        neg_y;
        logic [1:0]  shift;
        logic        q_zero;
    } geom_t;

    typedef struct packed {
        particle_t    part;
        cap_t         cap;
        geom_t [1:0]  geom;
    } side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] nq;
        logic [62:0] den;
    } div1_t;

    typedef struct packed {
        logic [34:0] rem;
        logic [30:0] nq;
        logic [33:0] den;
    } div2_t;

endpackage

// File: hw/rtl/two_attractor_particle_step.sv
// Top level: pipelined semi-implicit Euler step of a particle under two attractors.
//
//  channel   dir   handshake              payload
//  s_        in    s_tvalid / s_tready    s_tdata : particle state and time step
//  m_        out   m_tvalid / m_tready    m_tdata : new state, m_tuser : capture code
//  cfg_      in    cfg_wr_en              cfg_index, cfg_wdata : attractor registers
//
// One request per cycle sustained while a low m_tready does not stall the output.
// The latency is set by the pull divider (64 quotient bits, two per stage); the root
// extractor and the direction dividers run alongside it in the same 32 stages.
// Reset (aresetn low, synchronous) empties the pipeline and restores the registers.
// A stall on m_tready freezes every stage together; nothing is dropped or repeated.
module two_attractor_particle_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], time_step[143:128]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x[31:0], new_pos_y[63:32], new_vel_x[95:64], new_vel_y[127:96]
    output logic [127:0] m_tdata,
    // captured[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int LAT = tap_pkg::LATENCY;
    localparam int NS1 = tap_pkg::DIV1_STAGES;
    localparam int NSQ = tap_pkg::SQRT_STAGES;
    localparam int NS2 = tap_pkg::DIV2_STAGES;

    // ---------------------------------------------------------------- helpers
    function automatic tap_pkg::sqrt_t sqrt_step(input tap_pkg::sqrt_t a,
                                                 input logic [5:0] bitpos);
        logic [63:0]     bv;
        logic [63:0]     t;
        tap_pkg::sqrt_t  r;
        bv = 64'd1 << bitpos;
        t  = a.root + bv;
        if (a.n >= t) begin
            r.n    = a.n - t;
            r.root = (a.root >> 1) + bv;
        end else begin
            r.n    = a.n;
            r.root = a.root >> 1;
        end
        return r;
    endfunction

    function automatic tap_pkg::div1_t div1_step(input tap_pkg::div1_t a);
        logic [64:0]     sh;
        logic            ge;
        tap_pkg::div1_t  r;
        sh    = {a.rem, a.nq[63]};
        ge    = (sh >= {2'b00, a.den});
        r.den = a.den;
        r.nq  = {a.nq[62:0], ge};
        r.rem = ge ? 64'(sh - {2'b00, a.den}) : sh[63:0];
        return r;
    endfunction

    function automatic tap_pkg::div2_t div2_step(input tap_pkg::div2_t a);
        logic [34:0]     sh;
        logic            ge;
        tap_pkg::div2_t  r;
        sh    = {a.rem[33:0], a.nq[30]};
        ge    = (sh >= {1'b0, a.den});
        r.den = a.den;
        r.nq  = {a.nq[29:0], ge};
        r.rem = ge ? (sh - {1'b0, a.den}) : sh;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > 35'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -35'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

    // ---------------------------------------------------------------- control
    logic en;
    logic vld_reg [LAT];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------------------------------------------------------- registers
    logic signed [31:0] bx_reg [2];
    logic signed [31:0] by_reg [2];
    logic [30:0]        br_reg [2];
    logic [31:0]        bs_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_reg[0] <= tap_pkg::B1_X_RST;
            by_reg[0] <= tap_pkg::B1_Y_RST;
            br_reg[0] <= tap_pkg::B1_R_RST;
            bs_reg[0] <= tap_pkg::B1_S_RST;
            bx_reg[1] <= tap_pkg::B2_X_RST;
            by_reg[1] <= tap_pkg::B2_Y_RST;
            br_reg[1] <= tap_pkg::B2_R_RST;
            bs_reg[1] <= tap_pkg::B2_S_RST;
        end else if (cfg_wr_en) begin
            case (tap_pkg::cfg_idx_t'(cfg_index))
                tap_pkg::REG_B1_X: bx_reg[0] <= cfg_wdata;
                tap_pkg::REG_B1_Y: by_reg[0] <= cfg_wdata;
                tap_pkg::REG_B1_R: br_reg[0] <= cfg_wdata[30:0];
                tap_pkg::REG_B1_S: bs_reg[0] <= cfg_wdata;
                tap_pkg::REG_B2_X: bx_reg[1] <= cfg_wdata;
                tap_pkg::REG_B2_Y: by_reg[1] <= cfg_wdata;
                tap_pkg::REG_B2_R: br_reg[1] <= cfg_wdata[30:0];
                tap_pkg::REG_B2_S: bs_reg[1] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 1: offsets
    tap_pkg::particle_t in_part;
    tap_pkg::particle_t s1_part_reg;
    logic signed [32:0] s1_dx_reg [2];
    logic signed [32:0] s1_dy_reg [2];

    assign in_part.pos_x = s_tdata[31:0];
    assign in_part.pos_y = s_tdata[63:32];
    assign in_part.vel_x = s_tdata[95:64];
    assign in_part.vel_y = s_tdata[127:96];
    assign in_part.dt    = s_tdata[143:128];

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_part_reg <= in_part;
            for (int b = 0; b < 2; b++) begin
                s1_dx_reg[b] <= {bx_reg[b][31], bx_reg[b]} - {in_part.pos_x[31], in_part.pos_x};
                s1_dy_reg[b] <= {by_reg[b][31], by_reg[b]} - {in_part.pos_y[31], in_part.pos_y};
            end
        end
    end

    // ---------------------------------------------------------------- stage 2: magnitudes
    tap_pkg::particle_t s2_part_reg;
    logic [32:0] s2_ax_reg [2];
    logic [32:0] s2_ay_reg [2];
    logic        s2_nx_reg [2];
    logic        s2_ny_reg [2];
    logic [1:0]  s2_k_reg  [2];
    logic [30:0] s2_mxk_reg [2];
    logic [30:0] s2_myk_reg [2];
    logic        s2_le_reg [2];

    logic [32:0] ax_c [2];
    logic [32:0] ay_c [2];
    logic [1:0]  k_c  [2];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            ax_c[b] = s1_dx_reg[b][32] ? 33'(-s1_dx_reg[b]) : 33'(s1_dx_reg[b]);
            ay_c[b] = s1_dy_reg[b][32] ? 33'(-s1_dy_reg[b]) : 33'(s1_dy_reg[b]);
            // drop low bits until both magnitudes fit below 2^31
            if (ax_c[b][32] || ay_c[b][32]) begin
                k_c[b] = 2'd2;
            end else if (ax_c[b][31] || ay_c[b][31]) begin
                k_c[b] = 2'd1;
            end else begin
                k_c[b] = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_part_reg <= s1_part_reg;
            for (int b = 0; b < 2; b++) begin
                s2_ax_reg[b]  <= ax_c[b];
                s2_ay_reg[b]  <= ay_c[b];
                s2_nx_reg[b]  <= s1_dx_reg[b][32];
                s2_ny_reg[b]  <= s1_dy_reg[b][32];
                s2_k_reg[b]   <= k_c[b];
                s2_mxk_reg[b] <= 31'(ax_c[b] >> k_c[b]);
                s2_myk_reg[b] <= 31'(ay_c[b] >> k_c[b]);
                s2_le_reg[b]  <= (ax_c[b] <= {2'b00, br_reg[b]}) &&
                                 (ay_c[b] <= {2'b00, br_reg[b]});
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: squares
    tap_pkg::particle_t s3_part_reg;
    logic [32:0] s3_ax_reg [2];
    logic [32:0] s3_ay_reg [2];
    logic        s3_nx_reg [2];
    logic        s3_ny_reg [2];
    logic [1:0]  s3_k_reg  [2];
    logic        s3_le_reg [2];
    logic [61:0] s3_sqx_reg [2];
    logic [61:0] s3_sqy_reg [2];
    logic [61:0] s3_cx_reg [2];
    logic [61:0] s3_cy_reg [2];
    logic [61:0] s3_rr_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_part_reg <= s2_part_reg;
            for (int b = 0; b < 2; b++) begin
                s3_ax_reg[b]  <= s2_ax_reg[b];
                s3_ay_reg[b]  <= s2_ay_reg[b];
                s3_nx_reg[b]  <= s2_nx_reg[b];
                s3_ny_reg[b]  <= s2_ny_reg[b];
                s3_k_reg[b]   <= s2_k_reg[b];
                s3_le_reg[b]  <= s2_le_reg[b];
                s3_sqx_reg[b] <= 62'(s2_mxk_reg[b]) * 62'(s2_mxk_reg[b]);
                s3_sqy_reg[b] <= 62'(s2_myk_reg[b]) * 62'(s2_myk_reg[b]);
                // only meaningful when both magnitudes are within the radius
                s3_cx_reg[b]  <= 62'(s2_ax_reg[b][30:0]) * 62'(s2_ax_reg[b][30:0]);
                s3_cy_reg[b]  <= 62'(s2_ay_reg[b][30:0]) * 62'(s2_ay_reg[b][30:0]);
                s3_rr_reg[b]  <= 62'(br_reg[b]) * 62'(br_reg[b]);
            end
        end
    end

    // ---------------------------------------------------------------- stage 4: Q and capture
    tap_pkg::side_t s4_side_reg;
    logic [62:0]    s4_q_reg [2];
    logic [62:0]    q_c  [2];
    logic           in_c [2];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            q_c[b]  = {1'b0, s3_sqx_reg[b]} + {1'b0, s3_sqy_reg[b]};
            in_c[b] = s3_le_reg[b] &&
                      (({1'b0, s3_cx_reg[b]} + {1'b0, s3_cy_reg[b]}) <= {1'b0, s3_rr_reg[b]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_side_reg.part <= s3_part_reg;
            if (in_c[0]) begin
                s4_side_reg.cap <= tap_pkg::CAP_FIRST;
            end else if (in_c[1]) begin
                s4_side_reg.cap <= tap_pkg::CAP_SECOND;
            end else begin
                s4_side_reg.cap <= tap_pkg::CAP_FREE;
            end
            for (int b = 0; b < 2; b++) begin
                s4_side_reg.geom[b].mag_x  <= s3_ax_reg[b];
                s4_side_reg.geom[b].mag_y  <= s3_ay_reg[b];
                s4_side_reg.geom[b].neg_x  <= s3_nx_reg[b];
                s4_side_reg.geom[b].neg_y  <= s3_ny_reg[b];
                s4_side_reg.geom[b].shift  <= s3_k_reg[b];
                s4_side_reg.geom[b].q_zero <= (q_c[b] == 63'd0);
                s4_q_reg[b]                <= q_c[b];
            end
        end
    end

    // ---------------------------------------------------------------- core: root, pull, direction
    // Pull divider: S*2^32 / Q, 64 quotient bits.
    // Root extractor: isqrt(Q), 32 bits, then d = root << k.
    // Direction dividers: |offset|*2^30 / d, 31 quotient bits, one per axis.
    tap_pkg::side_t side_reg  [NS1];
    tap_pkg::side_t side_next [NS1];
    tap_pkg::div1_t d1_reg  [2][NS1];
    tap_pkg::div1_t d1_next [2][NS1];
    tap_pkg::sqrt_t sq_reg  [2][NSQ];
    tap_pkg::sqrt_t sq_next [2][NSQ];
    tap_pkg::div2_t dv_reg  [2][2][NS2];
    tap_pkg::div2_t dv_next [2][2][NS2];

    always_comb begin
        tap_pkg::div1_t a1;
        tap_pkg::sqrt_t as;
        tap_pkg::div2_t a2;
        tap_pkg::geom_t gm;
        logic [33:0]    den;
        logic [32:0]    mg;

        side_next[0] = s4_side_reg;
        for (int j = 1; j < NS1; j++) side_next[j] = side_reg[j-1];

        for (int b = 0; b < 2; b++) begin
            // pull divider
            a1.rem = 64'd0;
            a1.nq  = {bs_reg[b], 32'd0};
            a1.den = s4_q_reg[b];
            d1_next[b][0] = div1_step(div1_step(a1));
            for (int j = 1; j < NS1; j++) begin
                d1_next[b][j] = div1_step(div1_step(d1_reg[b][j-1]));
            end

            // root extractor, trial bits from 2^62 downward
            as.n    = {1'b0, s4_q_reg[b]};
            as.root = 64'd0;
            sq_next[b][0] = sqrt_step(sqrt_step(as, 6'd62), 6'd60);
            for (int j = 1; j < NSQ; j++) begin
                sq_next[b][j] = sqrt_step(sqrt_step(sq_reg[b][j-1], 6'(62 - 4 * j)),
                                          6'(60 - 4 * j));
            end

            // direction dividers; the quotient is known to stay below 2^31
            gm  = side_reg[NSQ-1].geom[b];
            den = 34'(sq_reg[b][NSQ-1].root[31:0]) << gm.shift;
            for (int a = 0; a < 2; a++) begin
                mg     = (a == 0) ? gm.mag_x : gm.mag_y;
                a2.rem = 35'(mg >> 1);
                a2.nq  = {mg[0], 30'd0};
                a2.den = den;
                dv_next[b][a][0] = div2_step(div2_step(a2));
                for (int j = 1; j < NS2; j++) begin
                    a2 = div2_step(dv_reg[b][a][j-1]);
                    if (2 * j + 1 < tap_pkg::DIV2_STEPS) a2 = div2_step(a2);
                    dv_next[b][a][j] = a2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            d1_reg   <= d1_next;
            sq_reg   <= sq_next;
            dv_reg   <= dv_next;
        end
    end

    // ---------------------------------------------------------------- tail 1: scale and clamp pull
    tap_pkg::side_t m1_side_reg;
    logic [30:0]    m1_u_reg [2][2];
    logic [61:0]    m1_g_reg [2];
    logic [63:0]    g_c [2];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            g_c[b] = d1_reg[b][NS1-1].nq >> {side_reg[NS1-1].geom[b].shift, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_side_reg <= side_reg[NS1-1];
            for (int b = 0; b < 2; b++) begin
                // at 2^61 or more any nonzero direction saturates anyway
                m1_g_reg[b] <= (g_c[b][63:61] != 3'd0) ? {1'b1, 61'd0} : g_c[b][61:0];
                for (int a = 0; a < 2; a++) m1_u_reg[b][a] <= dv_reg[b][a][NS2-1].nq;
            end
        end
    end

    // ---------------------------------------------------------------- tail 2: partial products
    tap_pkg::side_t m2_side_reg;
    logic [61:0]    m2_plo_reg [2][2];
    logic [61:0]    m2_phi_reg [2][2];

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_side_reg <= m1_side_reg;
            for (int b = 0; b < 2; b++) begin
                for (int a = 0; a < 2; a++) begin
                    m2_plo_reg[b][a] <= 62'(m1_g_reg[b][30:0]) * 62'(m1_u_reg[b][a]);
                    m2_phi_reg[b][a] <= 62'(m1_g_reg[b][61:31]) * 62'(m1_u_reg[b][a]);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tail 3: per-axis acceleration
    tap_pkg::particle_t m3_part_reg;
    tap_pkg::cap_t      m3_cap_reg;
    logic signed [31:0] m3_acc_reg [2][2];
    logic signed [31:0] acc_c [2][2];

    always_comb begin
        logic [92:0] p;
        logic [31:0] mc;
        logic        neg;
        for (int b = 0; b < 2; b++) begin
            for (int a = 0; a < 2; a++) begin
                p   = {m2_phi_reg[b][a], 31'd0} + 93'(m2_plo_reg[b][a]);
                mc  = (p[92:30] > 63'h0000_0000_8000_0000) ? 32'h8000_0000 : p[61:30];
                neg = (a == 0) ? m2_side_reg.geom[b].neg_x : m2_side_reg.geom[b].neg_y;
                if (m2_side_reg.geom[b].q_zero) begin
                    acc_c[b][a] = 32'sd0;
                end else if (neg) begin
                    acc_c[b][a] = -$signed(mc);
                end else begin
                    acc_c[b][a] = mc[31] ? 32'sh7fffffff : $signed(mc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_part_reg <= m2_side_reg.part;
            m3_cap_reg  <= m2_side_reg.cap;
            m3_acc_reg  <= acc_c;
        end
    end

    // ---------------------------------------------------------------- tail 4..8: integrate
    tap_pkg::particle_t m4_part_reg, m5_part_reg, m6_part_reg, m7_part_reg;
    tap_pkg::cap_t      m4_cap_reg, m5_cap_reg, m6_cap_reg, m7_cap_reg;
    logic signed [32:0] m4_ax_reg, m4_ay_reg;
    logic signed [49:0] m5_pax_reg, m5_pay_reg;
    logic signed [31:0] m6_nvx_reg, m6_nvy_reg;
    logic signed [31:0] m7_nvx_reg, m7_nvy_reg;
    logic signed [48:0] m7_pvx_reg, m7_pvy_reg;
    logic signed [31:0] o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    tap_pkg::cap_t      o_cap_reg;

    logic signed [16:0] dt5_s, dt7_s;
    logic signed [31:0] npx_c, npy_c;

    assign dt5_s = $signed({1'b0, m4_part_reg.dt});
    assign dt7_s = $signed({1'b0, m6_part_reg.dt});
    assign npx_c = sat32(35'(m7_part_reg.pos_x) + 35'($signed(m7_pvx_reg[48:16])));
    assign npy_c = sat32(35'(m7_part_reg.pos_y) + 35'($signed(m7_pvy_reg[48:16])));

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_part_reg <= m3_part_reg;
            m4_cap_reg  <= m3_cap_reg;
            m4_ax_reg   <= 33'(m3_acc_reg[0][0]) + 33'(m3_acc_reg[1][0]);
            m4_ay_reg   <= 33'(m3_acc_reg[0][1]) + 33'(m3_acc_reg[1][1]);

            m5_part_reg <= m4_part_reg;
            m5_cap_reg  <= m4_cap_reg;
            m5_pax_reg  <= 50'(m4_ax_reg) * 50'(dt5_s);
            m5_pay_reg  <= 50'(m4_ay_reg) * 50'(dt5_s);

            // velocity first: floor of the scaled step is the top slice
            m6_part_reg <= m5_part_reg;
            m6_cap_reg  <= m5_cap_reg;
            m6_nvx_reg  <= sat32(35'(m5_part_reg.vel_x) + 35'($signed(m5_pax_reg[49:16])));
            m6_nvy_reg  <= sat32(35'(m5_part_reg.vel_y) + 35'($signed(m5_pay_reg[49:16])));

            m7_part_reg <= m6_part_reg;
            m7_cap_reg  <= m6_cap_reg;
            m7_nvx_reg  <= m6_nvx_reg;
            m7_nvy_reg  <= m6_nvy_reg;
            m7_pvx_reg  <= 49'(m6_nvx_reg) * 49'(dt7_s);
            m7_pvy_reg  <= 49'(m6_nvy_reg) * 49'(dt7_s);

            // captured particles come back untouched
            o_cap_reg <= m7_cap_reg;
            if (m7_cap_reg != tap_pkg::CAP_FREE) begin
                o_px_reg <= m7_part_reg.pos_x;
                o_py_reg <= m7_part_reg.pos_y;
                o_vx_reg <= m7_part_reg.vel_x;
                o_vy_reg <= m7_part_reg.vel_y;
            end else begin
                o_px_reg <= npx_c;
                o_py_reg <= npy_c;
                o_vx_reg <= m7_nvx_reg;
                o_vy_reg <= m7_nvy_reg;
            end
        end
    end

    assign m_tdata = {o_vy_reg, o_vx_reg, o_py_reg, o_px_reg};
    assign m_tuser = o_cap_reg;

endmodule
